// File: src/csv_field_tokenizer_top_assert.svh
// Assertion macros for the CSV field tokenizer.
// No dependencies; taken in by the files that carry assertions.
`ifndef CSV_FIELD_TOKENIZER_TOP_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, held off while reset is high.
`define CSVFT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csvft assertion failed");
// Clocked check that also holds during reset.
`define CSVFT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("csvft assertion failed");
`else
`define CSVFT_ASSERT(lbl, clk, rst, prop)
`define CSVFT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/csvft_pkg.sv
// Shared types and constants of the CSV field tokenizer.
// No dependencies; used by csvft_step, the top level and the testbench.
`default_nettype none

package csvft_pkg;

  // request codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // token kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  // result queue depth, power of two, at least 2
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic in_quoted;
    logic quote_held;
    logic return_held;
    logic line_begun;
  } csvft_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } csvft_token_t;

  // what one byte produces: up to two tokens, in order
  typedef struct packed {
    logic [1:0]   count;
    csvft_token_t tok0;
    csvft_token_t tok1;
  } csvft_emit_t;

endpackage

`default_nettype wire

// File: src/csvft_if.sv
// Channel interfaces of the CSV field tokenizer: byte input, token output,
// delimiter write. No dependencies.
`default_nettype none

interface csvft_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_in;
  modport source (output valid, output operation, output char_in, input ready);
  modport sink (input valid, input operation, input char_in, output ready);
endinterface

interface csvft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] char_out;
  logic       last_of_run;
  modport source (output valid, output token_kind, output char_out, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input char_out, input last_of_run,
                output ready);
endinterface

interface csvft_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/csvft_step.sv
// Per-byte decision logic: next tokenizer state and the tokens one request yields.
// Depends on csvft_pkg. Purely combinational.
`default_nettype none

module csvft_step (
  input  csvft_pkg::csvft_state_t st,
  input  logic                    operation,
  input  logic [7:0]              char_in,
  input  logic [7:0]              delimiter_char,
  output csvft_pkg::csvft_state_t st_next,
  output csvft_pkg::csvft_emit_t  emit
);

  logic                    quoted;
  logic                    a_vld;
  logic                    b_vld;
  csvft_pkg::csvft_token_t a_tok;
  csvft_pkg::csvft_token_t b_tok;

  always_comb begin
    st_next = st;
    quoted  = 1'b0;
    a_vld   = 1'b0;
    b_vld   = 1'b0;
    a_tok   = '0;
    b_tok   = '0;
    if (operation == csvft_pkg::OP_END || char_in == csvft_pkg::CH_LF) begin
      // line end: row mark only when the line holds something
      a_vld      = st.line_begun;
      a_tok.kind = csvft_pkg::KIND_ROW;
      st_next    = '0;
    end else if (st.quote_held && char_in == csvft_pkg::CH_QUOTE) begin
      // doubled quote
      st_next.quote_held = 1'b0;
      a_vld      = 1'b1;
      a_tok.kind = csvft_pkg::KIND_DATA;
      a_tok.ch   = csvft_pkg::CH_QUOTE;
    end else begin
      // a lone held quote closes the quoted section
      quoted              = st.in_quoted & ~st.quote_held;
      st_next.quote_held  = 1'b0;
      st_next.in_quoted   = quoted;
      st_next.return_held = 1'b0;
      if (st.return_held) begin
        st_next.line_begun = 1'b1;
        if (quoted) begin
          a_vld      = 1'b1;
          a_tok.kind = csvft_pkg::KIND_DATA;
          a_tok.ch   = csvft_pkg::CH_CR;
        end else if (delimiter_char == csvft_pkg::CH_CR) begin
          a_vld      = 1'b1;
          a_tok.kind = csvft_pkg::KIND_FIELD;
        end
      end
      if (char_in == csvft_pkg::CH_CR) begin
        st_next.return_held = 1'b1;
      end else begin
        st_next.line_begun = 1'b1;
        if (char_in == csvft_pkg::CH_QUOTE) begin
          if (quoted) begin
            st_next.quote_held = 1'b1;
          end else begin
            st_next.in_quoted = 1'b1;
          end
        end else if (!quoted && char_in == delimiter_char) begin
          b_vld      = 1'b1;
          b_tok.kind = csvft_pkg::KIND_FIELD;
        end else begin
          b_vld      = 1'b1;
          b_tok.kind = csvft_pkg::KIND_DATA;
          b_tok.ch   = char_in;
        end
      end
    end
  end

  // pack into slot order and mark the last token of the request
  always_comb begin
    emit       = '0;
    emit.count = {1'b0, a_vld} + {1'b0, b_vld};
    if (a_vld) begin
      emit.tok0      = a_tok;
      emit.tok1      = b_tok;
      emit.tok0.last = ~b_vld;
      emit.tok1.last = b_vld;
    end else begin
      emit.tok0      = b_tok;
      emit.tok0.last = b_vld;
    end
  end

endmodule

`default_nettype wire

// File: src/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: state registers, delimiter register,
// token queue. Depends on csvft_pkg, csvft_if.sv, csvft_step and the assert header.
// A byte-serial CSV tokenizer. Each accepted request carries one content byte
// (operation 0) or an end-of-content mark (operation 1) and yields zero, one or
// two tokens: data bytes, end-of-field marks and end-of-row marks, the last
// token of each request flagged by last_of_run. Quoted fields, doubled quotes
// and carriage-return dropping follow the usual CSV rules; a newline always
// ends the row, even inside quotes. The four state flags update in the cycle
// a request is accepted, so one request can be taken every clock while ready is
// high. Tokens go into a small queue (QueueDepth entries) and leave one per clock
// while the sink is ready; a token shows on the output once the tokens ahead of
// it have left. Input ready holds while the queue has room for two tokens, so the
// sustained rate is one request per cycle as long as the sink takes one token per
// cycle; requests that yield two tokens are then bounded by that single output
// port. The delimiter register resets to a comma and is written over the cfg
// channel, which is always ready; write it only while the block is idle.
`default_nettype none

`include "csv_field_tokenizer_top_assert.svh"

module csv_field_tokenizer_top #(
  parameter int QueueDepth = csvft_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  csvft_in_if.sink    byte_in,
  csvft_out_if.source token_out,
  csvft_cfg_if.sink   cfg
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  // tokenizer state
  csvft_pkg::csvft_state_t st;
  csvft_pkg::csvft_state_t st_next;
  csvft_pkg::csvft_emit_t  emit;
  logic [7:0]              delimiter_char;

  // token queue
  csvft_pkg::csvft_token_t mem [QueueDepth];
  logic [PtrW-1:0]         wr_ptr;
  logic [PtrW-1:0]         rd_ptr;
  logic [CntW-1:0]         count;
  logic [1:0]              n_push;
  logic                    push;
  logic                    pop;

  // request that closes the line
  logic                    line_end_req;

  csvft_step u_step (
    .st             (st),
    .operation      (byte_in.operation),
    .char_in        (byte_in.char_in),
    .delimiter_char (delimiter_char),
    .st_next        (st_next),
    .emit           (emit)
  );

  // leave room for the worst case of two tokens per request
  assign byte_in.ready = (count <= CntW'(QueueDepth - 2));
  assign push          = byte_in.valid & byte_in.ready;
  assign n_push        = push ? emit.count : 2'd0;
  assign pop           = token_out.valid & token_out.ready;

  assign line_end_req = (byte_in.operation == csvft_pkg::OP_END) ||
                        (byte_in.char_in == csvft_pkg::CH_LF);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= '0;
      delimiter_char <= csvft_pkg::DELIM_RESET;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (push) begin
        st <= st_next;
      end
      if (cfg.valid && cfg.ready) begin
        delimiter_char <= cfg.data;
      end
      wr_ptr <= PtrW'(wr_ptr + PtrW'(n_push));
      if (pop) begin
        rd_ptr <= PtrW'(rd_ptr + PtrW'(1));
      end
      count <= CntW'(count + CntW'(n_push) - CntW'(pop));
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= emit.tok0;
    end
    if (n_push == 2'd2) begin
      mem[PtrW'(wr_ptr + PtrW'(1))] <= emit.tok1;
    end
  end

  assign token_out.valid       = (count != '0);
  assign token_out.token_kind  = mem[rd_ptr].kind;
  assign token_out.char_out    = mem[rd_ptr].ch;
  assign token_out.last_of_run = mem[rd_ptr].last;

  // queue never overfills
  `CSVFT_ASSERT(a_count_bound, clk, rst, count <= CntW'(QueueDepth))
  // a line end clears all of the tokenizer state
  `CSVFT_ASSERT(a_line_end_clears, clk, rst, (push && line_end_req) |=> (st == '0))
  // a held quote only exists inside a quoted section
  `CSVFT_ASSERT(a_quote_in_quotes, clk, rst, st.quote_held |-> st.in_quoted)
  // held quote and held carriage return are never pending together
  `CSVFT_ASSERT(a_holds_exclusive, clk, rst, !(st.quote_held && st.return_held))
  // reset leaves an empty queue and cleared flags
  `CSVFT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (count == '0 && st == '0))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for csv_field_tokenizer_top: directed probe table, then random CSV
// records under several separator settings. Depends on csvft_pkg, csvft_if.sv and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // package names used here
  localparam logic       OP_BYTE     = csvft_pkg::OP_BYTE;
  localparam logic       OP_END      = csvft_pkg::OP_END;
  localparam logic [1:0] KIND_DATA   = csvft_pkg::KIND_DATA;
  localparam logic [1:0] KIND_FIELD  = csvft_pkg::KIND_FIELD;
  localparam logic [1:0] KIND_ROW    = csvft_pkg::KIND_ROW;
  localparam logic [7:0] CH_QUOTE    = csvft_pkg::CH_QUOTE;
  localparam logic [7:0] CH_CR       = csvft_pkg::CH_CR;
  localparam logic [7:0] CH_LF       = csvft_pkg::CH_LF;
  localparam logic [7:0] DELIM_RESET = csvft_pkg::DELIM_RESET;

  typedef csvft_pkg::csvft_token_t csvft_token_t;

  // -1 in the probe table: the tokens come from the scanner model below
  localparam int FROM_PREDICTOR = -1;
  localparam int NUM_PROBES     = 26;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_REQUESTS = 200;
  // quiet cycles allowed before giving up: far longer than the longest source gap,
  // sink stall or settle pause, so many times the slowest legal silence
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_PRINTED    = 30;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    int         n_want;  // tokens typed in below, or FROM_PREDICTOR
    logic [1:0] kind;
    logic [7:0] tok_ch;
  } probe_row_t;

  logic clk;
  logic rst;

  csvft_in_if  in_ch ();
  csvft_out_if out_ch ();
  csvft_cfg_if cfg_ch ();

  csv_field_tokenizer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (in_ch),
    .token_out (out_ch),
    .cfg       (cfg_ch)
  );

  // ---------------------------------------------------------------------------------------
  // Scanner model: its own copy of the separator and the four line flags.
  // ---------------------------------------------------------------------------------------
  logic [7:0] sep_char;
  logic       quoted_mode;    // inside a quoted section
  logic       quote_pending;  // quote seen inside quotes, next byte decides
  logic       cr_pending;     // CR waiting to see whether a newline follows
  logic       row_open;       // line has content, so a newline gives a row end

  csvft_token_t step_toks[$];   // tokens of the request being modelled
  csvft_token_t owed_tokens[$]; // tokens the block still has to deliver, oldest first

  int  requests_sent;
  int  tokens_checked;
  int  data_seen;
  int  field_ends_seen;
  int  row_ends_seen;
  int  mismatches;
  int  quiet_cycles;
  bit  steady_flow;  // when set neither side idles

  function automatic void add_token(logic [1:0] kind, logic [7:0] ch);
    csvft_token_t t;
    t.kind = kind;
    t.ch   = (kind == KIND_DATA) ? ch : 8'h00;
    t.last = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  // a held CR that turned out not to end the line
  function automatic void keep_return();
    row_open = 1'b1;
    if (quoted_mode) add_token(KIND_DATA, CH_CR);
    else if (sep_char == CH_CR) add_token(KIND_FIELD, 8'h00);
  endfunction

  function automatic void keep_byte(logic [7:0] c);
    row_open = 1'b1;
    if (quoted_mode) begin
      if (c == CH_QUOTE) quote_pending = 1'b1;
      else add_token(KIND_DATA, c);
    end else if (c == CH_QUOTE) begin
      quoted_mode = 1'b1;   // quote meaning wins over a quote separator
    end else if (c == sep_char) begin
      add_token(KIND_FIELD, 8'h00);
    end else begin
      add_token(KIND_DATA, c);
    end
  endfunction

  function automatic void scan_request(logic op, logic [7:0] c);
    logic         settled;
    step_toks.delete();
    settled = 1'b0;
    if (op == OP_END || c == CH_LF) begin
      // end of line closes everything, an open quote included; empty lines give nothing
      if (row_open) add_token(KIND_ROW, 8'h00);
      quoted_mode   = 1'b0;
      quote_pending = 1'b0;
      cr_pending    = 1'b0;
      row_open      = 1'b0;
    end else begin
      if (quote_pending) begin
        quote_pending = 1'b0;
        if (c == CH_QUOTE) begin
          add_token(KIND_DATA, CH_QUOTE);   // doubled quote
          settled = 1'b1;
        end else begin
          quoted_mode = 1'b0;
        end
      end
      if (!settled) begin
        if (cr_pending) begin
          cr_pending = 1'b0;
          keep_return();
        end
        if (c == CH_CR) cr_pending = 1'b1;
        else keep_byte(c);
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Mismatch reporting and token checking.
  // ---------------------------------------------------------------------------------------
  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
    else if (mismatches == MAX_PRINTED + 1) $display("further mismatches not printed");
  endtask

  // Handshakes are sampled at the falling edge: everything is driven at the rising edge,
  // so valid and ready seen here are exactly what the next rising edge acts on.
  always @(negedge clk) begin : check_tokens
    csvft_token_t want;
    if (!rst && (out_ch.valid & out_ch.ready) === 1'b1) begin
      tokens_checked++;
      case (out_ch.token_kind)
        KIND_DATA:  data_seen++;
        KIND_FIELD: field_ends_seen++;
        KIND_ROW:   row_ends_seen++;
        default: ;
      endcase
      if (owed_tokens.size() == 0) begin
        note_mismatch($sformatf("token kind %0d char %02h last %b with nothing owed",
                                out_ch.token_kind, out_ch.char_out, out_ch.last_of_run));
      end else begin
        want = owed_tokens.pop_front();
        if (out_ch.token_kind !== want.kind)
          note_mismatch($sformatf("token_kind %0d, want %0d", out_ch.token_kind, want.kind));
        if (out_ch.char_out !== want.ch)
          note_mismatch($sformatf("char_out %02h, want %02h", out_ch.char_out, want.ch));
        if (out_ch.last_of_run !== want.last)
          note_mismatch($sformatf("last_of_run %b, want %b", out_ch.last_of_run, want.last));
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(negedge clk) begin
    if ((in_ch.valid & in_ch.ready) === 1'b1 || (out_ch.valid & out_ch.ready) === 1'b1 ||
        (cfg_ch.valid & cfg_ch.ready) === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d tokens still owed",
                 quiet_cycles, owed_tokens.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Clock, reset, token sink.
  // ---------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short idles, a few long ones; none at all while steady_flow is set
  function automatic int idle_cycles();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  initial begin : token_sink
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      hold = idle_cycles();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request driving.
  // ---------------------------------------------------------------------------------------

  // One request. Called at a rising edge; returns at the edge that accepted it.
  task automatic send_request(logic op, logic [7:0] c, int n_want, logic [1:0] kind,
                              logic [7:0] tok_ch);
    csvft_token_t t;
    int           gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.char_in   <= c;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    scan_request(op, c);
    if (n_want != FROM_PREDICTOR) begin
      // typed-in expectation replaces the model's; the model still tracks the state
      step_toks.delete();
      if (n_want == 1) begin
        t.kind = kind;
        t.ch   = tok_ch;
        t.last = 1'b1;
        step_toks = {step_toks, t};
      end
    end
    owed_tokens = {owed_tokens, step_toks};
    requests_sent++;
  endtask

  task automatic send_byte(logic [7:0] c);
    send_request(OP_BYTE, c, FROM_PREDICTOR, KIND_DATA, 8'h00);
  endtask

  task automatic send_end();
    send_request(OP_END, 8'($urandom_range(0, 255)), FROM_PREDICTOR, KIND_DATA, 8'h00);
  endtask

  // Stop sending, let every owed token arrive, then a short pause for anything in flight.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (owed_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(logic [7:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    do @(negedge clk); while (cfg_ch.ready !== 1'b1);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sep_char = d;
  endtask

  // a field byte with no special meaning under the current separator
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_CR || c == CH_LF || c == sep_char);
    return c;
  endfunction

  // a well-formed line: plain and quoted fields, then LF, CRLF, end of content or CR plus end
  task automatic send_record();
    int fields;
    int len;
    int r;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) send_byte(sep_char);
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        send_byte(CH_QUOTE);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 19);
          if (r < 3) begin
            send_byte(CH_QUOTE);
            send_byte(CH_QUOTE);
          end else if (r < 5) begin
            send_byte(CH_CR);
          end else if (r < 7) begin
            send_byte(sep_char);
          end else begin
            send_byte(plain_byte());
          end
        end
        send_byte(CH_QUOTE);
      end else begin
        for (int k = 0; k < len; k++) begin
          // stray CR outside quotes now and then
          if ($urandom_range(0, 19) == 0) send_byte(CH_CR);
          else send_byte(plain_byte());
        end
      end
    end
    r = $urandom_range(0, 9);
    if (r >= 5 && r != 8) send_byte(CH_CR);
    if (r >= 8) send_end();
    else send_byte(CH_LF);
    // occasional empty or CR-only line
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) send_byte(CH_CR);
      send_byte(CH_LF);
    end
  endtask

  // broken input: any byte, specials weighted up, stray end-of-content marks
  task automatic send_noise();
    int         n;
    int         r;
    logic [7:0] c;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 11);
      if (r == 0) begin
        send_end();
      end else begin
        c = 8'($urandom_range(0, 255));
        if (r == 1) c = CH_QUOTE;
        if (r == 2) c = CH_CR;
        if (r == 3) c = sep_char;
        if (r == 4) c = CH_LF;
        send_byte(c);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Directed probes, reset separator. Simple outcomes are typed in; the rest come from
  // the model.
  // ---------------------------------------------------------------------------------------
  probe_row_t probes [NUM_PROBES] = '{
    '{OP_END,  8'h00,       0,              KIND_DATA,  8'h00},     // nothing pending after reset
    '{OP_BYTE, 8'h61,       1,              KIND_DATA,  8'h61},
    '{OP_BYTE, DELIM_RESET, 1,              KIND_FIELD, 8'h00},
    '{OP_BYTE, 8'h00,       1,              KIND_DATA,  8'h00},     // lowest byte
    '{OP_BYTE, 8'hFF,       1,              KIND_DATA,  8'hFF},     // highest byte
    '{OP_BYTE, CH_QUOTE,    0,              KIND_DATA,  8'h00},     // open quotes
    '{OP_BYTE, DELIM_RESET, 1,              KIND_DATA,  DELIM_RESET}, // separator is data
    '{OP_BYTE, CH_QUOTE,    0,              KIND_DATA,  8'h00},     // quote held
    '{OP_BYTE, CH_QUOTE,    1,              KIND_DATA,  CH_QUOTE},  // doubled quote
    '{OP_BYTE, CH_QUOTE,    0,              KIND_DATA,  8'h00},
    '{OP_BYTE, DELIM_RESET, FROM_PREDICTOR, KIND_DATA,  8'h00},     // closes quotes, ends field
    '{OP_BYTE, CH_CR,       0,              KIND_DATA,  8'h00},
    '{OP_BYTE, CH_LF,       1,              KIND_ROW,   8'h00},     // CRLF ends the row
    '{OP_BYTE, CH_LF,       0,              KIND_DATA,  8'h00},     // empty line
    '{OP_BYTE, CH_CR,       0,              KIND_DATA,  8'h00},
    '{OP_BYTE, CH_LF,       0,              KIND_DATA,  8'h00},     // CR-only line
    '{OP_BYTE, CH_CR,       0,              KIND_DATA,  8'h00},
    '{OP_BYTE, 8'h62,       FROM_PREDICTOR, KIND_DATA,  8'h00},     // lone CR dropped
    '{OP_BYTE, CH_QUOTE,    0,              KIND_DATA,  8'h00},
    '{OP_BYTE, CH_CR,       0,              KIND_DATA,  8'h00},
    '{OP_BYTE, 8'h71,       FROM_PREDICTOR, KIND_DATA,  8'h00},     // CR kept in quotes: 2 tokens
    '{OP_BYTE, CH_QUOTE,    FROM_PREDICTOR, KIND_DATA,  8'h00},
    '{OP_BYTE, CH_LF,       1,              KIND_ROW,   8'h00},     // newline with quote held
    '{OP_BYTE, 8'h7A,       FROM_PREDICTOR, KIND_DATA,  8'h00},
    '{OP_BYTE, CH_CR,       0,              KIND_DATA,  8'h00},
    '{OP_END,  8'hFF,       1,              KIND_ROW,   8'h00}      // flush, trailing CR dropped
  };

  logic [7:0] phase_seps [NUM_PHASES];

  initial begin : stimulus
    int phase_end;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_BYTE;
    in_ch.char_in   = 8'h00;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = 8'h00;
    sep_char        = DELIM_RESET;
    quoted_mode     = 1'b0;
    quote_pending   = 1'b0;
    cr_pending      = 1'b0;
    row_open        = 1'b0;
    steady_flow     = 1'b0;
    requests_sent   = 0;
    tokens_checked  = 0;
    data_seen       = 0;
    field_ends_seen = 0;
    row_ends_seen   = 0;
    mismatches      = 0;
    quiet_cycles    = 0;

    // extremes first, then the specials, a middle value, a random one, back to comma
    phase_seps = '{8'h00, 8'hFF, CH_CR, CH_QUOTE, CH_LF, 8'h3B, 8'h00, DELIM_RESET};
    phase_seps[6] = 8'($urandom_range(0, 255));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i])
      send_request(probes[i].op, probes[i].ch, probes[i].n_want, probes[i].kind,
                   probes[i].tok_ch);
    settle_block();

    // random phases: mostly well-formed lines, some noise; the separator is only
    // rewritten once the block has gone quiet
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_separator(phase_seps[p]);
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        if ($urandom_range(0, 11) == 0) steady_flow = !steady_flow;
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_record();
      end
      settle_block();
    end

    if (owed_tokens.size() != 0)
      note_mismatch($sformatf("%0d tokens never delivered", owed_tokens.size()));

    $display("%0d requests (%0d directed) over %0d separator settings, %0d tokens checked",
             requests_sent, NUM_PROBES, NUM_PHASES + 1, tokens_checked);
    $display("tokens seen: %0d data bytes, %0d field ends, %0d row ends, %0d mismatches",
             data_seen, field_ends_seen, row_ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
